// ===== sv/int8_dot_product_requantize_assert.svh =====
// ----------------------------------------------------------------------------
// int8_dot_product_requantize assertion macros
// Short forms for the concurrent assertions of the requantizing dot product.
// ----------------------------------------------------------------------------
`ifndef INT8_DOT_PRODUCT_REQUANTIZE_ASSERT_SVH
`define INT8_DOT_PRODUCT_REQUANTIZE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IDP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("int8_dot_product_requantize: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define IDP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("int8_dot_product_requantize: assertion failed");

`endif

// ===== sv/idp_pkg.sv =====
// ----------------------------------------------------------------------------
// idp_pkg
// Shared types and constants of the int8 dot product requantizer.
// ----------------------------------------------------------------------------
package idp_pkg;

   localparam int ACC_WIDTH_DEFAULT = 32;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Requantization divides by 2**REQ_SHIFT (32), truncating toward zero.
   localparam int REQ_SHIFT = 5;
   localparam logic signed [15:0] REQ_LIMIT     = 16'sd32767;
   localparam logic signed [15:0] REQ_LIMIT_NEG = -16'sd32767;

   // x / 10 == (x * 0xCCCD) >> 19 for every 16-bit unsigned x.
   localparam logic [15:0] DIV10_MAGIC = 16'hCCCD;
   localparam int          DIV10_SHIFT = 19;

   // Smallest value the leaky activation can produce.
   localparam logic signed [15:0] LEAKY_FLOOR = -16'sd3276;

   typedef struct packed {
      logic signed [15:0] product;
      logic signed [15:0] bias;
      logic               last;
   } idp_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } idp_queue_status_type;

endpackage

// ===== sv/idp_front.sv =====
// ----------------------------------------------------------------------------
// idp_front
// Accepts items, forms the weight-activation product and queues it.
// ----------------------------------------------------------------------------
module idp_front (
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [7:0]             req_weight,
   input  logic signed [7:0]             req_activation,
   input  logic signed [15:0]            req_bias,
   input  logic                          req_last,
   input  idp_pkg::idp_queue_status_type status,
   output logic                          push,
   output idp_pkg::idp_entry_type        entry
);
   import idp_pkg::*;

   logic signed [15:0] product;

   // Both operands are signed, so -128 * -128 = 16384 fits in 16 bits.
   assign product = 16'(req_weight) * 16'(req_activation);

   assign req_stall     = status.full;
   assign push          = req_valid && !status.full;
   assign entry.product = product;
   assign entry.bias    = req_bias;
   assign entry.last    = req_last;

endmodule

// ===== sv/idp_queue.sv =====
// ----------------------------------------------------------------------------
// idp_queue
// Small FIFO that decouples the front from the accumulate pipeline.
// ----------------------------------------------------------------------------
module idp_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  idp_pkg::idp_entry_type        entry_in,
   input  logic                          pop,
   output idp_pkg::idp_entry_type        entry_out,
   output idp_pkg::idp_queue_status_type status
);
   import idp_pkg::*;

   idp_entry_type           entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= entry_in;
      end
   end

   assign entry_out    = entries_ff[rd_ptr_ff];
   assign status.full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

// ===== sv/idp_back.sv =====
// ----------------------------------------------------------------------------
// idp_back
// Accumulates products and requantizes the sum on each last item.
// ----------------------------------------------------------------------------
module idp_back #(
   parameter int ACC_WIDTH = idp_pkg::ACC_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          leaky_enable,
   input  idp_pkg::idp_queue_status_type status,
   input  idp_pkg::idp_entry_type        entry,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [15:0]            rsp_conv_out
);
   import idp_pkg::*;

   localparam int QW = ACC_WIDTH - REQ_SHIFT;

   logic                        advance;
   logic signed [ACC_WIDTH-1:0] sum;
   logic signed [ACC_WIDTH-1:0] acc_ff, acc_in;

   logic                        s1_valid_ff, s1_valid_in;
   logic signed [ACC_WIDTH-1:0] s1_sum_ff, s1_sum_in;
   logic signed [15:0]          s1_bias_ff, s1_bias_in;

   logic signed [ACC_WIDTH-1:0] adjusted;
   logic signed [QW-1:0]        quotient;
   logic signed [15:0]          clamped;
   logic                        s2_valid_ff, s2_valid_in;
   logic signed [15:0]          s2_q_ff, s2_q_in;
   logic signed [15:0]          s2_bias_ff, s2_bias_in;

   logic                        s3_valid_ff, s3_valid_in;
   logic signed [15:0]          s3_r_ff, s3_r_in;

   logic [15:0]                 magnitude;
   logic [31:0]                 scaled;
   logic [31-DIV10_SHIFT:0]     tenth;
   logic signed [15:0]          activated;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]          rsp_data_ff, rsp_data_in;

   // The whole pipeline moves when the output register is free or being taken.
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign pop     = advance && !status.empty;

   // Accumulate loop: wraps modulo 2**ACC_WIDTH, cleared after a last item.
   assign sum = acc_ff + ACC_WIDTH'(entry.product);

   always_comb begin
      acc_in = acc_ff;
      if (pop) begin
         acc_in = entry.last ? '0 : sum;
      end
      s1_valid_in = advance ? (pop && entry.last) : s1_valid_ff;
      s1_sum_in   = (pop && entry.last) ? sum : s1_sum_ff;
      s1_bias_in  = (pop && entry.last) ? entry.bias : s1_bias_ff;
   end

   // Divide by 32 toward zero: bias negative sums up before the arithmetic shift.
   always_comb begin
      adjusted = s1_sum_ff;
      if (s1_sum_ff[ACC_WIDTH-1]) begin
         adjusted = s1_sum_ff + ACC_WIDTH'((1 << REQ_SHIFT) - 1);
      end
      quotient = adjusted[ACC_WIDTH-1:REQ_SHIFT];
      if (quotient > QW'(REQ_LIMIT)) begin
         clamped = REQ_LIMIT;
      end else if (quotient < QW'(REQ_LIMIT_NEG)) begin
         clamped = REQ_LIMIT_NEG;
      end else begin
         clamped = quotient[15:0];
      end
      s2_valid_in = advance ? s1_valid_ff : s2_valid_ff;
      s2_q_in     = advance ? clamped : s2_q_ff;
      s2_bias_in  = advance ? s1_bias_ff : s2_bias_ff;
   end

   // Bias add wraps to 16 bits with no saturation.
   always_comb begin
      s3_valid_in = advance ? s2_valid_ff : s3_valid_ff;
      s3_r_in     = advance ? s2_q_ff + s2_bias_ff : s3_r_ff;
   end

   // If enabled, values <= 0 have their magnitude divided by ten, sign restored.
   always_comb begin
      magnitude = 16'(16'sd0 - s3_r_ff);
      scaled    = 32'(magnitude) * 32'(DIV10_MAGIC);
      tenth     = scaled[31:DIV10_SHIFT];
      activated = s3_r_ff;
      if (leaky_enable && (s3_r_ff <= 16'sd0)) begin
         activated = 16'(16'sd0 - signed'(16'(tenth)));
      end
      rsp_valid_in = advance ? s3_valid_ff : rsp_valid_ff;
      rsp_data_in  = advance ? activated : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_sum_ff   <= s1_sum_in;
      s1_bias_ff  <= s1_bias_in;
      s2_q_ff     <= s2_q_in;
      s2_bias_ff  <= s2_bias_in;
      s3_r_ff     <= s3_r_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_conv_out = rsp_data_ff;

endmodule

// ===== sv/int8_dot_product_requantize.sv =====
// ----------------------------------------------------------------------------
// int8_dot_product_requantize
// Streaming int8 multiply-accumulate with saturating 16-bit requantization.
// ----------------------------------------------------------------------------
// The block takes one weight-activation pair per cycle while req_stall is low
// and gives one 16-bit result for each item marked last. The limit of one item
// per cycle is set by the accumulate loop; a four-entry queue sits between the
// input side and the accumulator, so up to four more items are taken while a
// result waits to be taken. Each result passes through registered stages in
// order: accumulate, divide and clamp, bias add, then leaky activation into the
// output register. Write leaky_enable only while no dot product is in flight.
module int8_dot_product_requantize #(
   parameter int ACC_WIDTH = idp_pkg::ACC_WIDTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [7:0]  req_weight,
   input  logic signed [7:0]  req_activation,
   input  logic signed [15:0] req_bias,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_conv_out,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_write_data
);
   import idp_pkg::*;

   idp_queue_status_type status;
   idp_entry_type        push_entry;
   idp_entry_type        pop_entry;
   logic                 push;
   logic                 pop;
   logic                 leaky_enable_ff, leaky_enable_in;

   assign csr_ready       = 1'b1;
   assign leaky_enable_in = (csr_valid && csr_ready) ? csr_write_data : leaky_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         leaky_enable_ff <= 1'b0;
      end else begin
         leaky_enable_ff <= leaky_enable_in;
      end
   end

   idp_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_weight     (req_weight),
      .req_activation (req_activation),
      .req_bias       (req_bias),
      .req_last       (req_last),
      .status         (status),
      .push           (push),
      .entry          (push_entry)
   );

   idp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .entry_in  (push_entry),
      .pop       (pop),
      .entry_out (pop_entry),
      .status    (status)
   );

   idp_back #(
      .ACC_WIDTH (ACC_WIDTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .leaky_enable (leaky_enable_ff),
      .status       (status),
      .entry        (pop_entry),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_conv_out (rsp_conv_out)
   );

endmodule

// ===== sv/idp_checker.sv =====
// ----------------------------------------------------------------------------
// idp_checker
// Port-level checks of the int8 dot product requantizer, bound to the top.
// ----------------------------------------------------------------------------
`include "int8_dot_product_requantize_assert.svh"

module idp_checker (
   input logic               clock,
   input logic               reset,
   input logic               csr_valid,
   input logic               csr_ready,
   input logic               csr_write_data,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [15:0] rsp_conv_out
);
   import idp_pkg::*;

   logic leaky_mirror_ff, leaky_mirror_in;

   // Track the register from the port so results can be checked against it.
   assign leaky_mirror_in = (csr_valid && csr_ready) ? csr_write_data : leaky_mirror_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         leaky_mirror_ff <= 1'b0;
      end else begin
         leaky_mirror_ff <= leaky_mirror_in;
      end
   end

   `IDP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_conv_out))
   `IDP_ASSERT_NOW(a_leaky_floor, clock, reset, rsp_valid && leaky_mirror_ff, rsp_conv_out >= LEAKY_FLOOR)
   `IDP_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid)

endmodule

bind int8_dot_product_requantize idp_checker u_idp_checker (
   .clock          (clock),
   .reset          (reset),
   .csr_valid      (csr_valid),
   .csr_ready      (csr_ready),
   .csr_write_data (csr_write_data),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_conv_out   (rsp_conv_out)
);
